>>> src/spt_pkg.sv
// Package for the smooth pulse train: widths, register indexes, shared types.
// No dependencies.
package spt_pkg;
    localparam int unsigned FracBitsDef = 16;
    localparam int unsigned CoordW = 32;
    localparam int unsigned PerW = 31;
    localparam int unsigned OutW = 18;
    localparam int unsigned OutFrac = 16;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] RegEdge0 = 3'd0;
    localparam logic [CfgIdxW-1:0] RegEdge1 = 3'd1;
    localparam logic [CfgIdxW-1:0] RegEdge2 = 3'd2;
    localparam logic [CfgIdxW-1:0] RegEdge3 = 3'd3;
    localparam logic [CfgIdxW-1:0] RegPeriod = 3'd4;

    // remainder cell word: partial remainder (33 bit unsigned magnitude) and sign of x
    typedef struct packed {
        logic        vld;
        logic        neg;
        logic [32:0] rem;
    } t_rem_word;

    // divide cell word for the two ramps in parallel
    typedef struct packed {
        logic        vld;
        logic [32:0] num0;
        logic [32:0] num1;
        logic [32:0] w0;
        logic [32:0] w1;
        logic [1:0]  sat0;  // 0 below, 1 above, 2/3 in ramp
        logic [1:0]  sat1;
    } t_div_ctl;
endpackage

>>> src/spt_rem_cell.sv
// One restoring step of the floored remainder x mod period.
// Depends on spt_pkg.
module spt_rem_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [30:0]          i_period,
    input  spt_pkg::t_rem_word   i_word,
    output spt_pkg::t_rem_word   o_word
);
    spt_pkg::t_rem_word r_word;
    spt_pkg::t_rem_word n_word;
    logic [63:0] sub;

    // rem holds |x| reduced; subtract period << SHIFT if it fits
    assign sub = {33'd0, i_period} << SHIFT;

    always_comb begin
        n_word = i_word;
        if ({31'd0, i_word.rem} >= sub) begin
            n_word.rem = 33'({31'd0, i_word.rem} - sub);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word.vld <= n_word.vld;
        end
        if (i_en) begin
            r_word.neg <= n_word.neg;
            r_word.rem <= n_word.rem;
        end
    end
    assign o_word = r_word;
endmodule

>>> src/spt_div_cell.sv
// One quotient bit of t = (d << FRAC_BITS) / w for both ramps.
// Depends on spt_pkg.
module spt_div_cell #(
    parameter int unsigned FRAC_BITS = spt_pkg::FracBitsDef
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  spt_pkg::t_div_ctl      i_ctl,
    input  logic [FRAC_BITS-1:0]   i_q0,
    input  logic [FRAC_BITS-1:0]   i_q1,
    output spt_pkg::t_div_ctl      o_ctl,
    output logic [FRAC_BITS-1:0]   o_q0,
    output logic [FRAC_BITS-1:0]   o_q1
);
    spt_pkg::t_div_ctl    r_ctl;
    spt_pkg::t_div_ctl    n_ctl;
    logic [FRAC_BITS-1:0] r_q0, r_q1, n_q0, n_q1;
    logic [33:0]          s0, s1;

    // num < w on entry; shift left one, subtract if it fits
    always_comb begin
        n_ctl = i_ctl;
        s0 = {i_ctl.num0, 1'b0};
        s1 = {i_ctl.num1, 1'b0};
        n_q0 = {i_q0[FRAC_BITS-2:0], 1'b0};
        n_q1 = {i_q1[FRAC_BITS-2:0], 1'b0};
        if (s0 >= {1'b0, i_ctl.w0}) begin
            s0 = s0 - {1'b0, i_ctl.w0};
            n_q0[0] = 1'b1;
        end
        if (s1 >= {1'b0, i_ctl.w1}) begin
            s1 = s1 - {1'b0, i_ctl.w1};
            n_q1[0] = 1'b1;
        end
        n_ctl.num0 = s0[32:0];
        n_ctl.num1 = s1[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_ctl.vld <= n_ctl.vld;
        end
        if (i_en) begin
            r_ctl.num0 <= n_ctl.num0;
            r_ctl.num1 <= n_ctl.num1;
            r_ctl.w0   <= n_ctl.w0;
            r_ctl.w1   <= n_ctl.w1;
            r_ctl.sat0 <= n_ctl.sat0;
            r_ctl.sat1 <= n_ctl.sat1;
            r_q0       <= n_q0;
            r_q1       <= n_q1;
        end
    end
    assign o_ctl = r_ctl;
    assign o_q0  = r_q0;
    assign o_q1  = r_q1;
endmodule

>>> src/smooth_pulse_train_top.sv
// Smooth pulse train top level: remainder chain, divide chain, polynomial stages.
// Depends on spt_pkg, spt_rem_cell and spt_div_cell.
//
// One word per cycle enters and one leaves while the output is not stalled; a word
// passes through 32 remainder cells, an edge stage, FRAC_BITS divide cells,
// then square, cubic and combine stages. The whole pipe advances when the
// output register is empty or being taken, so s_axis_tready follows m_axis_tready
// backpressure alone. Registers may be written only while the pipe is empty.
module smooth_pulse_train_top #(
    parameter int unsigned FRAC_BITS = spt_pkg::FracBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] coord
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [17:0] pulse_value, zero fill above
    input  logic        i_cfg_we,
    input  logic [spt_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int unsigned NRem = 32;
    localparam int unsigned PW = 2 * FRAC_BITS + 2;

    logic signed [31:0] r_edge0, r_edge1, r_edge2, r_edge3;
    logic [30:0] r_period;
    logic        en;
    logic        r_out_vld;
    logic [17:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge0 <= '0; r_edge1 <= '0; r_edge2 <= '0; r_edge3 <= '0;
            r_period <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spt_pkg::RegEdge0:  r_edge0 <= i_cfg_data;
                spt_pkg::RegEdge1:  r_edge1 <= i_cfg_data;
                spt_pkg::RegEdge2:  r_edge2 <= i_cfg_data;
                spt_pkg::RegEdge3:  r_edge3 <= i_cfg_data;
                spt_pkg::RegPeriod: r_period <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // advance when the output register is free
    assign en = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    spt_pkg::t_rem_word rw [NRem+1];
    always_comb begin
        rw[0].vld = s_axis_tvalid;
        rw[0].neg = s_axis_tdata[31];
        rw[0].rem = s_axis_tdata[31] ? 33'(-{1'b1, s_axis_tdata})
                                     : {1'b0, s_axis_tdata};
    end
    for (genvar g = 0; g < NRem; g++) begin : g_rem
        spt_rem_cell #(.SHIFT(NRem - 1 - g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_period(r_period),
            .i_word(rw[g]), .o_word(rw[g+1])
        );
    end

    // edge stage: fold sign, compare, form offset and width
    logic signed [33:0] rr;
    logic [1:0] sa0, sa1;
    spt_pkg::t_div_ctl r_dc;
    always_comb begin
        if (r_period == '0) rr = '0;
        else if (rw[NRem].neg && rw[NRem].rem != '0)
            rr = 34'($signed({3'd0, r_period})) - $signed({1'b0, rw[NRem].rem});
        else rr = $signed({1'b0, rw[NRem].rem});
        sa0 = (rr < 34'(r_edge0)) ? 2'd0 : (rr >= 34'(r_edge1)) ? 2'd1 : 2'd2;
        sa1 = (rr < 34'(r_edge2)) ? 2'd0 : (rr >= 34'(r_edge3)) ? 2'd1 : 2'd2;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dc.vld <= 1'b0;
        else if (en) r_dc.vld <= rw[NRem].vld;
        if (en) begin
            r_dc.sat0 <= sa0;
            r_dc.sat1 <= sa1;
            r_dc.num0 <= 33'(rr - 34'(r_edge0));
            r_dc.num1 <= 33'(rr - 34'(r_edge2));
            r_dc.w0   <= 33'(34'(r_edge1) - 34'(r_edge0));
            r_dc.w1   <= 33'(34'(r_edge3) - 34'(r_edge2));
        end
    end

    spt_pkg::t_div_ctl    dc [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] q0 [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] q1 [FRAC_BITS+1];
    assign dc[0] = r_dc;
    assign q0[0] = '0;
    assign q1[0] = '0;
    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_div
        spt_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(dc[g]), .i_q0(q0[g]), .i_q1(q1[g]),
            .o_ctl(dc[g+1]), .o_q0(q0[g+1]), .o_q1(q1[g+1])
        );
    end

    // square stage
    logic                 r_v1;
    logic [1:0]           r_s0a, r_s1a;
    logic [FRAC_BITS-1:0] r_t0, r_t1, r_t20, r_t21;
    logic [2*FRAC_BITS-1:0] sq0, sq1;
    assign sq0 = q0[FRAC_BITS] * q0[FRAC_BITS];
    assign sq1 = q1[FRAC_BITS] * q1[FRAC_BITS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en) r_v1 <= dc[FRAC_BITS].vld;
        if (en) begin
            r_s0a <= dc[FRAC_BITS].sat0; r_s1a <= dc[FRAC_BITS].sat1;
            r_t0 <= q0[FRAC_BITS]; r_t1 <= q1[FRAC_BITS];
            r_t20 <= sq0[2*FRAC_BITS-1:FRAC_BITS];
            r_t21 <= sq1[2*FRAC_BITS-1:FRAC_BITS];
        end
    end

    // cubic stage: t2 * (3 - 2t)
    logic            r_v2;
    logic [1:0]      r_s0b, r_s1b;
    logic [PW-1:0]   r_p0, r_p1;
    logic [FRAC_BITS+1:0] po0, po1;
    assign po0 = (FRAC_BITS+2)'(3 << FRAC_BITS) - {1'b0, r_t0, 1'b0};
    assign po1 = (FRAC_BITS+2)'(3 << FRAC_BITS) - {1'b0, r_t1, 1'b0};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en) r_v2 <= r_v1;
        if (en) begin
            r_s0b <= r_s0a; r_s1b <= r_s1a;
            r_p0 <= r_t20 * po0;
            r_p1 <= r_t21 * po1;
        end
    end

    // scale to 16 fraction bits and subtract
    function automatic logic [17:0] scale(input logic [1:0] s, input logic [PW-1:0] p);
        logic [PW+15:0] v;
        begin
            v = {16'd0, p >> FRAC_BITS};
            if (FRAC_BITS >= spt_pkg::OutFrac) v = v >> (FRAC_BITS - spt_pkg::OutFrac);
            else v = v << (spt_pkg::OutFrac - FRAC_BITS);
            if (s == 2'd0) scale = '0;
            else if (s == 2'd1) scale = 18'd65536;
            else scale = v[17:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (en) r_out_vld <= r_v2;
        if (en) r_out <= scale(r_s0b, r_p0) - scale(r_s1b, r_p1);
    end
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(r_out) <= 18'sd65536 && $signed(r_out) >= -18'sd65536))
        else $error("pulse value out of range");
endmodule
